// File: rtl/counter_bank_max_tracker_core_macros.svh
// Assertion helpers for the counter bank; clocked on clk, off during reset.
`ifndef COUNTER_BANK_MAX_TRACKER_CORE_MACROS_SVH
`define COUNTER_BANK_MAX_TRACKER_CORE_MACROS_SVH

// Check an expression at every rising clock edge.
`define CBMT_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define CBMT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/cbmt_pkg.sv
package cbmt_pkg;

    // Request codes
    typedef enum logic [1:0] {
        REQ_INC   = 2'd0,
        REQ_DEC   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_QUERY = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_INDEX = 2'd1,
        STAT_SATURATED = 2'd2
    } status_t;

    localparam int REQ_W    = $bits(req_t);
    localparam int STATUS_W = $bits(status_t);
    localparam int IDX_W_IN = 8;
    localparam int ACT_W    = 9;
    localparam int S_DATA_W = ((REQ_W + IDX_W_IN + 7) / 8) * 8;

endpackage

// File: rtl/counter_bank_max_tracker_core.sv
// Channel   Dir  Payload (low bit first)                              Transfer
// s_*       in   req_type[1:0], counter_index[9:2]                    s_tvalid & s_tready
// m_*       out  counter_value, max_value, max_holders, status        m_tvalid & m_tready
// cfg_*     in   active_counters                                      cfg_we
//
// A request passes through accept, read-modify-write of the counter memory and
// result load. When the only counter at the maximum drops, a rescan of the
// memory through its single read port adds a pass over the active counters.
// After reset and after every cfg write the memory is swept to zero, one entry
// a cycle over the active counters, with s_tready low.
// A finished result waits in the output register; the next request is accepted
// meanwhile, and only its result load waits for m_tready.

`include "counter_bank_max_tracker_core_macros.svh"

module counter_bank_max_tracker_core #(
    parameter int NUM_COUNTERS = 256,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write
    input  logic                          cfg_we,
    input  logic [cbmt_pkg::ACT_W-1:0]    cfg_active_counters,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // req_type, counter_index, zero fill
    input  logic [cbmt_pkg::S_DATA_W-1:0] s_tdata,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // counter_value, max_value, max_holders, status, zero fill
    output logic [((2 * COUNT_WIDTH + cbmt_pkg::ACT_W + cbmt_pkg::STATUS_W + 7) / 8) * 8 - 1:0]
                                          m_tdata
);

    import cbmt_pkg::*;

    localparam int ADDR_W       = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
    localparam int CNT_W        = (ADDR_W + 1 > 10) ? ADDR_W + 1 : 10;
    localparam int RES_BITS     = 2 * COUNT_WIDTH + ACT_W + STATUS_W;
    localparam int M_DATA_W     = ((RES_BITS + 7) / 8) * 8;
    localparam int RESET_ACTIVE = (NUM_COUNTERS < 256) ? NUM_COUNTERS : 256;
    localparam logic signed [COUNT_WIDTH-1:0] CNT_HI = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_LO = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // control state
    state_t                          state_reg, state_next;
    logic [ACT_W-1:0]                active_reg, active_next;
    logic signed [COUNT_WIDTH-1:0]   max_reg, max_next;
    logic [ACT_W-1:0]                holders_reg, holders_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            pend_reg, pend_next;
    logic                            first_reg, first_next;
    logic                            m_tvalid_reg, m_tvalid_next;

    // payload
    req_t                            req_reg;
    logic [CNT_W-1:0]                idx_reg;
    logic                            bad_reg;
    logic signed [COUNT_WIDTH-1:0]   res_value_reg, res_value_next;
    status_t                         res_status_reg, res_status_next;
    logic [M_DATA_W-1:0]             out_data_reg;

    // counter memory
    logic signed [COUNT_WIDTH-1:0]   mem [NUM_COUNTERS];
    logic signed [COUNT_WIDTH-1:0]   rd_data_reg;
    logic [ADDR_W-1:0]               rd_addr;
    logic [ADDR_W-1:0]               wr_addr;
    logic signed [COUNT_WIDTH-1:0]   wr_data;
    logic                            wr_en;

    // request decode
    logic                            s_xfer;
    logic [IDX_W_IN-1:0]             in_idx;
    logic                            in_bad;
    logic [CNT_W-1:0]                cnt_inc;
    logic [CNT_W-1:0]                active_ext;
    logic                            scan_issue;
    logic                            out_free;
    logic [ACT_W-1:0]                cfg_clamped;

    // read-modify-write datapath
    logic signed [COUNT_WIDTH-1:0]   old_val;
    logic signed [COUNT_WIDTH-1:0]   new_val;
    logic                            sat;
    logic                            changed;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_xfer     = s_tvalid && s_tready;
    assign in_idx     = s_tdata[REQ_W +: IDX_W_IN];
    assign in_bad     = ({1'b0, in_idx} >= active_reg);
    assign cnt_inc    = cnt_reg + 1'b1;
    assign active_ext = CNT_W'(active_reg);
    assign scan_issue = (cnt_reg < active_ext);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = out_data_reg;

    // Clamp a written counter count to 1 .. NUM_COUNTERS
    always_comb
    begin
        if (cfg_active_counters == '0)
        begin
            cfg_clamped = ACT_W'(1);
        end
        else if (CNT_W'(cfg_active_counters) > CNT_W'(NUM_COUNTERS))
        begin
            cfg_clamped = ACT_W'(NUM_COUNTERS);
        end
        else
        begin
            cfg_clamped = cfg_active_counters;
        end
    end

    // Apply the request to the counter read from memory
    always_comb
    begin
        old_val = rd_data_reg;
        new_val = rd_data_reg;
        sat     = 1'b0;
        case (req_reg)
            REQ_INC:
            begin
                if (old_val == CNT_HI)
                begin
                    sat = 1'b1;
                end
                else
                begin
                    new_val = old_val + 1'b1;
                end
            end
            REQ_DEC:
            begin
                if (old_val == CNT_LO)
                begin
                    sat = 1'b1;
                end
                else
                begin
                    new_val = old_val - 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                new_val = '0;
            end
            default:
            begin
                new_val = old_val;
            end
        endcase
        changed = !bad_reg && (new_val != old_val);
    end

    // Memory port selection
    always_comb
    begin
        rd_addr = (state_reg == ST_SCAN) ? cnt_reg[ADDR_W-1:0] : ADDR_W'(in_idx);
        wr_en   = 1'b0;
        wr_addr = idx_reg[ADDR_W-1:0];
        wr_data = new_val;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[ADDR_W-1:0];
                wr_data = '0;
            end
            ST_READ:
            begin
                wr_en = changed;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        max_next        = max_reg;
        holders_next    = holders_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        first_next      = first_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc == active_ext)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next      = ST_FINISH;
                res_value_next  = bad_reg ? '0 : new_val;
                res_status_next = bad_reg ? STAT_BAD_INDEX
                                          : (sat ? STAT_SATURATED : STAT_OK);
                // track the maximum through the change
                if (changed)
                begin
                    if (new_val > max_reg)
                    begin
                        max_next     = new_val;
                        holders_next = ACT_W'(1);
                    end
                    else if (new_val == max_reg)
                    begin
                        holders_next = holders_reg + 1'b1;
                    end
                    else if (old_val == max_reg)
                    begin
                        if (holders_reg > ACT_W'(1))
                        begin
                            holders_next = holders_reg - 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                            cnt_next   = '0;
                            pend_next  = 1'b0;
                            first_next = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // issue one read a cycle, fold the data of the previous one
                if (scan_issue)
                begin
                    cnt_next = cnt_inc;
                end
                pend_next = scan_issue;
                if (pend_reg)
                begin
                    first_next = 1'b0;
                    if (first_reg || (rd_data_reg > max_reg))
                    begin
                        max_next     = rd_data_reg;
                        holders_next = ACT_W'(1);
                    end
                    else if (rd_data_reg == max_reg)
                    begin
                        holders_next = holders_reg + 1'b1;
                    end
                end
                if (!scan_issue && !pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a register write rebuilds the bank
        if (cfg_we)
        begin
            active_next  = cfg_clamped;
            max_next     = '0;
            holders_next = cfg_clamped;
            cnt_next     = '0;
            state_next   = ST_CLEAR;
        end
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            active_reg   <= ACT_W'(RESET_ACTIVE);
            max_reg      <= '0;
            holders_reg  <= ACT_W'(RESET_ACTIVE);
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            first_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            max_reg      <= max_next;
            holders_reg  <= holders_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            first_reg    <= first_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Capture request and result payload
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            req_reg <= req_t'(s_tdata[REQ_W-1:0]);
            idx_reg <= CNT_W'(in_idx);
            bad_reg <= in_bad;
        end
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (state_reg == ST_FINISH && out_free)
        begin
            out_data_reg <= M_DATA_W'({res_status_reg, holders_reg, max_reg, res_value_reg});
        end
    end

    // Counter memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    `CBMT_ASSERT_HOLDS(a_holders_range, (holders_reg != '0) && (holders_reg <= active_reg), "max holder count out of range")
    `CBMT_ASSERT_IMPLIES(a_bad_no_write, (state_reg == ST_READ) && bad_reg, !wr_en, "write on a bad index")
    `CBMT_ASSERT_IMPLIES(a_out_from_finish, $rose(m_tvalid_reg), $past(state_reg) == ST_FINISH, "result shown outside finish")
    `CBMT_ASSERT_IMPLIES(a_scan_bound, state_reg == ST_SCAN, cnt_reg <= active_ext, "rescan ran past active counters")

endmodule

// File: verif/tb_counter_bank_max_tracker_core.sv
module tb_counter_bank_max_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cbmt_pkg::*;

    localparam int NUM_CNT      = 256;
    localparam int CNT_W        = 16;
    localparam int M_DATA_W     = ((2 * CNT_W + ACT_W + STATUS_W + 7) / 8) * 8;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam logic signed [CNT_W-1:0] CNT_TOP    = 16'sh7FFF;
    localparam logic signed [CNT_W-1:0] CNT_BOTTOM = 16'sh8000;

    // One result as the block reports it
    typedef struct {
        logic signed [CNT_W-1:0] count;
        logic signed [CNT_W-1:0] peak;
        logic [ACT_W-1:0]        holders;
        status_t                 status;
    } tally_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [ACT_W-1:0]    cfg_active_counters;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // req_type, counter_index, zero fill
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // counter_value, max_value, max_holders, status, zero fill

    // Predicted bank state
    logic signed [CNT_W-1:0] bank_model [NUM_CNT];
    logic signed [CNT_W-1:0] peak_val;
    int unsigned             peak_count;
    int unsigned             n_active;

    tally_t pending_tallies [$];

    int gap_pct;
    int stall_pct;
    bit hold_on;
    int fail_count;
    int items_sent;
    int results_checked;
    int cfg_writes;
    int sat_results;
    int cycle_count;

    counter_bank_max_tracker_core #(
        .NUM_COUNTERS (NUM_CNT),
        .COUNT_WIDTH  (CNT_W)
    ) u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_active_counters (cfg_active_counters),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Rebuild the predicted bank after a register write or reset
    function automatic void rebuild_bank(logic [ACT_W-1:0] value);
        int unsigned n;
        n = value;
        if (n < 1)
            n = 1;
        if (n > NUM_CNT)
            n = NUM_CNT;
        n_active = n;
        foreach (bank_model[k])
            bank_model[k] = '0;
        peak_val   = '0;
        peak_count = n;
    endfunction

    // Apply one request to the predicted bank and return its result
    function automatic tally_t predict_request(req_t op, logic [7:0] idx);
        tally_t t;
        logic signed [CNT_W-1:0] old_v;
        logic signed [CNT_W-1:0] new_v;
        t.status = STAT_OK;
        t.count  = '0;
        if (idx >= n_active)
        begin
            t.status = STAT_BAD_INDEX;
        end
        else
        begin
            old_v = bank_model[idx];
            new_v = old_v;
            case (op)
                REQ_INC:
                begin
                    if (old_v == CNT_TOP)
                        t.status = STAT_SATURATED;
                    else
                        new_v = old_v + 16'sd1;
                end
                REQ_DEC:
                begin
                    if (old_v == CNT_BOTTOM)
                        t.status = STAT_SATURATED;
                    else
                        new_v = old_v - 16'sd1;
                end
                REQ_CLEAR: new_v = '0;
                default: ;
            endcase
            if (new_v != old_v)
            begin
                bank_model[idx] = new_v;
                if (new_v > peak_val)
                begin
                    peak_val   = new_v;
                    peak_count = 1;
                end
                else if (new_v == peak_val)
                begin
                    peak_count++;
                end
                else if (old_v == peak_val)
                begin
                    if (peak_count > 1)
                    begin
                        peak_count--;
                    end
                    else
                    begin
                        // Sole holder left the maximum: rescan the active counters
                        peak_val   = bank_model[0];
                        peak_count = 1;
                        for (int k = 1; k < n_active; k++)
                        begin
                            if (bank_model[k] > peak_val)
                            begin
                                peak_val   = bank_model[k];
                                peak_count = 1;
                            end
                            else if (bank_model[k] == peak_val)
                            begin
                                peak_count++;
                            end
                        end
                    end
                end
            end
            t.count = new_v;
        end
        t.peak    = peak_val;
        t.holders = peak_count[ACT_W-1:0];
        return t;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < 10)
            $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Offer one request, idling first at random, and hold it until the transfer
    task automatic send_request(input req_t op, input logic [7:0] idx);
        tally_t expected;
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = {{(S_DATA_W - REQ_W - IDX_W_IN){1'b0}}, idx, op};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected = predict_request(op, idx);
        pending_tallies.insert(pending_tallies.size(), expected);
        items_sent++;
    endtask

    // Drop the request stream and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_tallies.size() != 0)
            @(posedge clk);
    endtask

    // Write the active count once the block is idle
    task automatic write_active(input logic [ACT_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_active_counters = value;
        cfg_we              = 1'b1;
        rebuild_bank(value);
        cfg_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Edges of the index field, every request kind, bad index and the count clamps
    task automatic test_directed();
        gap_pct   = 0;
        stall_pct = 0;
        send_request(REQ_QUERY, 8'd0);
        send_request(REQ_INC, 8'd255);
        send_request(REQ_DEC, 8'd255);
        send_request(REQ_DEC, 8'd0);
        send_request(REQ_CLEAR, 8'd0);
        send_request(REQ_CLEAR, 8'd7);
        send_request(REQ_INC, 8'hAA);
        send_request(REQ_INC, 8'h55);
        send_request(REQ_DEC, 8'hAA);
        send_request(REQ_QUERY, 8'h55);
        write_active(9'd10);
        send_request(REQ_INC, 8'd9);
        send_request(REQ_QUERY, 8'd10);
        send_request(REQ_DEC, 8'd255);
        write_active(9'd0);
        send_request(REQ_INC, 8'd0);
        send_request(REQ_INC, 8'd1);
        send_request(REQ_DEC, 8'd0);
        send_request(REQ_DEC, 8'd0);
        write_active(9'd511);
        send_request(REQ_QUERY, 8'd255);
        write_active(9'd257);
        send_request(REQ_INC, 8'd128);
        send_request(REQ_CLEAR, 8'd128);
    endtask

    // Build a clear leader, then walk it down so the sole holder leaves the maximum
    task automatic test_leader_change();
        gap_pct   = 0;
        stall_pct = 0;
        write_active(9'd3);
        repeat (30)
            send_request(REQ_INC, 8'd0);
        repeat (10)
            send_request(REQ_INC, 8'd1);
        repeat (30)
            send_request(REQ_DEC, 8'd0);
        send_request(REQ_QUERY, 8'd2);
        send_request(REQ_CLEAR, 8'd1);
        send_request(REQ_QUERY, 8'd0);
        drain_results();
    endtask

    // Random traffic over three bank sizes drawn at random, nearly half on a small hot set
    task automatic test_random_traffic(input int gap, input int stall, input int n_items);
        int   pick;
        int   hot;
        req_t op;
        logic [7:0] idx;
        gap_pct   = gap;
        stall_pct = stall;
        repeat (3)
        begin
            pick = $urandom_range(0, 3);
            case (pick)
                0: write_active(ACT_W'($urandom_range(1, 4)));
                1: write_active(ACT_W'($urandom_range(5, 32)));
                2: write_active(ACT_W'($urandom_range(1, 256)));
                default: write_active(9'd256);
            endcase
            hot = (n_active < 4) ? n_active : 4;
            repeat (n_items / 3)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    idx = 8'($urandom_range(0, hot - 1));
                else if (pick < 85)
                    idx = 8'($urandom_range(0, n_active - 1));
                else
                    idx = 8'($urandom_range(0, 255));
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    op = REQ_INC;
                else if (pick < 70)
                    op = REQ_DEC;
                else if (pick < 80)
                    op = REQ_CLEAR;
                else
                    op = REQ_QUERY;
                send_request(op, idx);
            end
        end
        drain_results();
    endtask

    // Hold the result side for a long stretch while requests keep coming
    task automatic test_output_hold();
        gap_pct   = 0;
        stall_pct = 0;
        write_active(9'd8);
        fork
            begin
                hold_on = 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_on = 1'b0;
            end
            begin
                repeat (40)
                    send_request(req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 8)));
            end
        join
        drain_results();
    endtask

    // Drive the result-side ready at the falling edge
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = !hold_on && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        tally_t got;
        tally_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.count   = m_tdata[CNT_W-1:0];
            got.peak    = m_tdata[2*CNT_W-1:CNT_W];
            got.holders = m_tdata[2*CNT_W+ACT_W-1:2*CNT_W];
            got.status  = status_t'(m_tdata[2*CNT_W+ACT_W+STATUS_W-1:2*CNT_W+ACT_W]);
            if (pending_tallies.size() == 0)
            begin
                note_failure("result transfer with nothing expected");
            end
            else
            begin
                want = pending_tallies.pop_front();
                results_checked++;
                if (got.status == STAT_SATURATED)
                    sat_results++;
                if (got.count !== want.count || got.peak !== want.peak
                    || got.holders !== want.holders || got.status !== want.status)
                    note_failure($sformatf(
                        "value %0d/%0d max %0d/%0d holders %0d/%0d status %s/%s (exp/got)",
                        want.count, got.count, want.peak, got.peak,
                        want.holders, got.holders, want.status.name(), got.status.name()));
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAIL counter_bank_max_tracker_core");
            $finish;
        end
    end

    // Reset, then run the tests in turn
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_active_counters = '0;
        s_tvalid            = 1'b0;
        s_tdata             = '0;
        hold_on             = 1'b0;
        gap_pct             = 0;
        stall_pct           = 0;
        fail_count          = 0;
        items_sent          = 0;
        results_checked     = 0;
        cfg_writes          = 0;
        sat_results         = 0;
        cycle_count         = 0;
        rebuild_bank(9'd256);
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_leader_change();
        test_random_traffic(0, 0, 240);
        test_random_traffic(62, 0, 240);
        test_random_traffic(0, 62, 240);
        test_random_traffic(14, 14, 240);
        test_output_hold();

        // Let the pipeline settle, then report
        drain_results();
        repeat (10)
            @(posedge clk);
        if (pending_tallies.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_tallies.size()));
        $display("Sent %0d requests over %0d register writes, checked %0d results (%0d saturated).",
                 items_sent, cfg_writes, results_checked, sat_results);
        $display("Covered idle and stall phases, a %0d-cycle output hold, %0d failures.",
                 HOLD_CYCLES, fail_count);
        if (fail_count == 0)
            $display("PASS counter_bank_max_tracker_core");
        else
            $display("FAIL counter_bank_max_tracker_core");
        $finish;
    end

endmodule
